/* hdl/nbbr_pkg.sv */
// Shared types and constants of the NAND bad-block remap unit.
package nbbr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int BLOCK_BITS  = 12;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    // A mapped block can run past the device by up to one block per table entry.
    localparam int VAL_W       = BLOCK_BITS + COUNT_W;
    localparam int S_TDATA_W   = ((BLOCK_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W  = BLOCK_BITS + 4 + COUNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [BLOCK_BITS-1:0] LAST_BLOCK = {BLOCK_BITS{1'b1}};

    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [VAL_W-1:0]      val_t;

    typedef enum logic [0:0] {
        CMD_MAP    = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    // Request travelling down the row of cells, one cell per cycle.
    // For a map, val is the running physical block; for an insert it holds the
    // entry being carried towards the tail in its low bits.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        val_t val;
        logic wr_en;
        logic dup;
        logic ins;
    } tok_t;

endpackage

/* hdl/nbbr_cell.sv */
// One table cell: holds a bad-block entry and processes the passing request.
module nbbr_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  nbbr_pkg::tok_t  tok_in,
    input  logic            occupied,
    input  logic            is_tail,
    output nbbr_pkg::tok_t  tok_out
);

    nbbr_pkg::block_t entry_reg;
    nbbr_pkg::block_t entry_next;
    nbbr_pkg::tok_t   tok_reg;
    nbbr_pkg::tok_t   tok_next;
    nbbr_pkg::val_t   entry_ext;
    nbbr_pkg::block_t carry;

    assign entry_ext = {{nbbr_pkg::COUNT_W{1'b0}}, entry_reg};
    assign carry     = tok_in.val[nbbr_pkg::BLOCK_BITS-1:0];

    always_comb begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        if (tok_in.valid) begin
            if (tok_in.cmd == nbbr_pkg::CMD_MAP) begin
                // Every bad block at or below the running position pushes it on by one.
                if (occupied && (entry_ext <= tok_in.val)) begin
                    tok_next.val = tok_in.val + nbbr_pkg::val_t'(1);
                end
            end else if (occupied) begin
                if (!tok_in.dup && (entry_reg == carry)) begin
                    tok_next.dup = 1'b1;
                end else if (tok_in.wr_en && !tok_in.dup && (carry < entry_reg)) begin
                    // Swap: keep the smaller value here, carry the larger one on.
                    entry_next   = carry;
                    tok_next.val = entry_ext;
                end
            end else if (is_tail && tok_in.wr_en && !tok_in.dup) begin
                entry_next   = carry;
                tok_next.ins = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;

endmodule

/* hdl/nand_bad_block_remap_unit.sv */
// Top level of the NAND bad-block remap unit: stream ports, entry count and result register.
//
// The unit keeps an ascending table of up to 64 bad physical block numbers in a
// row of cells, one entry per cell, and serves one request at a time. A map
// request (tuser 0) returns the physical number of the logical-th good block,
// counting from zero and skipping every bad block; a result past the last block
// of the device is saturated to the last block and flagged out_of_range. An
// insert request (tuser 1) adds a bad block at its sorted place, moving the
// larger entries up by one cell; a block already present is flagged duplicate
// and a full table is flagged table_full, both leaving the table unchanged (a
// duplicate into a full table reports duplicate). Each request walks the row
// of cells one cell per clock, and the result beat is offered from the result
// register once the request has left the last cell. The next input beat is
// taken in the cycle after the previous result beat has been accepted
// downstream. The input is not ready while reset is held. The table is empty
// after reset; entry contents need no clearing because only cells below the
// entry count take part.
module nand_bad_block_remap_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nbbr_pkg::S_TDATA_W-1:0]    s_tdata,  // [11:0] block
    input  logic                              s_tuser,  // [0] cmd: 0 map, 1 insert
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] phys_block, [12] out_of_range, [13] inserted, [14] duplicate,
    // [15] table_full, [22:16] bad_count
    output logic [nbbr_pkg::M_TDATA_W-1:0]    m_tdata
);

    nbbr_pkg::tok_t   chain [nbbr_pkg::TABLE_DEPTH+1];
    nbbr_pkg::tok_t   tail;
    nbbr_pkg::count_t count_reg;
    nbbr_pkg::count_t count_next;
    logic             busy_reg;
    logic             busy_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [nbbr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [nbbr_pkg::M_TDATA_W-1:0] m_tdata_next;
    logic             s_accept;
    logic             m_accept;

    // Result fields formed when a request leaves the last cell.
    nbbr_pkg::block_t res_phys;
    logic             res_over;
    logic             res_full;

    assign s_tready = aresetn && !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid_reg && m_tready;

    // A new request enters the first cell in the beat it is accepted.
    always_comb begin
        chain[0]       = '0;
        chain[0].valid = s_accept;
        chain[0].cmd   = nbbr_pkg::cmd_t'(s_tuser);
        chain[0].val   = {{nbbr_pkg::COUNT_W{1'b0}}, s_tdata[nbbr_pkg::BLOCK_BITS-1:0]};
        // Writes are allowed only while a free cell remains.
        chain[0].wr_en = (count_reg < nbbr_pkg::count_t'(nbbr_pkg::TABLE_DEPTH));
    end

    // The entry count stays fixed while a request walks the row, so each cell
    // sees whether it holds a live entry or is the first free one.
    for (genvar i = 0; i < nbbr_pkg::TABLE_DEPTH; i++) begin : g_cell
        nbbr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .tok_in   (chain[i]),
            .occupied (nbbr_pkg::count_t'(i) < count_reg),
            .is_tail  (nbbr_pkg::count_t'(i) == count_reg),
            .tok_out  (chain[i+1])
        );
    end

    assign tail = chain[nbbr_pkg::TABLE_DEPTH];

    always_comb begin
        res_over = 1'b0;
        res_phys = '0;
        res_full = 1'b0;
        if (tail.cmd == nbbr_pkg::CMD_MAP) begin
            res_over = (tail.val > {{nbbr_pkg::COUNT_W{1'b0}}, nbbr_pkg::LAST_BLOCK});
            res_phys = res_over ? nbbr_pkg::LAST_BLOCK
                                : tail.val[nbbr_pkg::BLOCK_BITS-1:0];
        end else begin
            // An insert that neither found its block nor stored it met a full table.
            res_full = !tail.dup && !tail.ins;
        end
    end

    always_comb begin
        count_next    = count_reg;
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_accept) begin
            busy_next = 1'b1;
        end
        if (m_accept) begin
            m_tvalid_next = 1'b0;
            busy_next     = 1'b0;
        end
        if (tail.valid) begin
            count_next    = count_reg + nbbr_pkg::count_t'(tail.ins);
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[nbbr_pkg::M_FIELDS_W-1:0] = {
                count_reg + nbbr_pkg::count_t'(tail.ins),
                res_full,
                tail.dup,
                tail.ins,
                res_over,
                res_phys
            };
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
